// ===== design/dcg_pkg.sv =====
package dcg_pkg;

  // Default build-time dimensions.
  localparam int CELL_SIZE_DEF   = 32;
  localparam int MAX_CELLS_X_DEF = 64;
  localparam int MAX_CELLS_Y_DEF = 64;

  // Width of the shared divider's dividend and quotient.
  localparam int DIV_W = 17;

  // Width of the surface size registers.
  localparam int SURF_W = 12;

  // Item kinds.
  localparam logic [1:0] KIND_BEGIN  = 2'd0;
  localparam logic [1:0] KIND_ADD    = 2'd1;
  localparam logic [1:0] KIND_BUILD  = 2'd2;
  localparam logic [1:0] KIND_DAMAGE = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_SURF_WIDTH  = 1'b0;
  localparam logic CFG_SURF_HEIGHT = 1'b1;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] rect_left;
    logic signed [15:0] rect_top;
    logic signed [15:0] rect_width;
    logic signed [15:0] rect_height;
    logic [5:0]         row_index;
  } in_item_t;

  typedef struct packed {
    logic [10:0] out_x;
    logic [10:0] out_y;
    logic [11:0] out_w;
    logic [11:0] out_h;
    logic        found;
    logic        last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CFG_X,
    ST_CFG_Y,
    ST_ADD_X1,
    ST_ADD_Y1,
    ST_ADD_X2,
    ST_ADD_Y2,
    ST_MARK_RD,
    ST_MARK_WR,
    ST_BLD_RD,
    ST_BLD_LD,
    ST_SCAN
  } state_t;

endpackage

// ===== design/dcg_ram.sv =====
module dcg_ram #(
  parameter int WIDTH  = 64,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/dcg_div.sv =====
module dcg_div
  import dcg_pkg::*;
#(
  parameter int CELL_SIZE = CELL_SIZE_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  logic [DIV_W-1:0] dividend,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  // Division by the constant cell size as a multiplication by its rounded-up
  // reciprocal. With a shift of DIV_W plus ceil(log2(CELL_SIZE)) the truncated
  // product equals the quotient for every dividend below 2**DIV_W.
  localparam int LG = $clog2(CELL_SIZE);
  localparam int SH = DIV_W + LG;
  localparam int MW = DIV_W + 1;
  localparam logic [MW-1:0] RECIP =
    MW'(((64'd1 << SH) + 64'(CELL_SIZE) - 64'd1) / 64'(CELL_SIZE));

  logic [DIV_W+MW-1:0] prod;
  logic [DIV_W-1:0]    quo_r, quo_nxt;
  logic                done_r, done_nxt;

  assign prod     = {{MW{1'b0}}, dividend} * {{DIV_W{1'b0}}, RECIP};
  assign quo_nxt  = go ? DIV_W'(prod >> SH) : quo_r;
  assign done_nxt = go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== design/damage_cell_grid_tracker.sv =====
// Tracks damaged screen cells in two bit grids (this frame and the last) and
// turns one cell row at a time into rectangles. An item is taken when start is
// high and busy is low; the block then stays busy until the item is finished.
// Results appear on out_data for exactly one cycle, marked by out_strobe, and
// cannot be held off, so the receiver must take every one as it comes. A begin
// frame item, an ignored region and a scan of a row outside the surface never
// raise busy. Every division by the cell size goes through one shared divider,
// a multiplication by the reciprocal that gives its quotient in the next cycle,
// so an add region item works out its four cell bounds one after another and
// then reads and writes the row memory once for each touched cell row. A build
// item fetches the row and then scans one cell column per cycle up to the last
// marked column, one run leaving per run end; a row with nothing marked gives
// its empty marker after the fetch. Each result appears in the cycle after the
// one that found it. A configuration write keeps the block busy while the
// divider works out the cell count. No clearing pass is needed after reset:
// each grid row carries a valid flag, cleared all at once.
module damage_cell_grid_tracker
  import dcg_pkg::*;
#(
  parameter int CELL_SIZE   = CELL_SIZE_DEF,
  parameter int MAX_CELLS_X = MAX_CELLS_X_DEF,
  parameter int MAX_CELLS_Y = MAX_CELLS_Y_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_item_t          in_data,
  output logic              out_strobe,
  output out_item_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [SURF_W-1:0] cfg_data
);

  // Widths of cell counts (which can reach the maximum itself) and of the row
  // memory address.
  localparam int XW   = $clog2(MAX_CELLS_X + 1);
  localparam int YW   = $clog2(MAX_CELLS_Y + 1);
  localparam int AW   = (MAX_CELLS_Y > 1) ? $clog2(MAX_CELLS_Y) : 1;
  localparam int CS_W = $clog2(CELL_SIZE + 1);
  localparam logic [CS_W-1:0]        CS_V  = CS_W'(CELL_SIZE);
  localparam logic [11:0]            OUT_H = 12'(CELL_SIZE);
  localparam logic [MAX_CELLS_X-1:0] ONES  = '1;

  state_t                 state_r, state_nxt;
  logic                   cur_bank_r, cur_bank_nxt;
  logic [MAX_CELLS_Y-1:0] valid_a_r, valid_a_nxt;
  logic [MAX_CELLS_Y-1:0] valid_b_r, valid_b_nxt;
  logic [XW-1:0]          cells_x_r, cells_x_nxt;
  logic [YW-1:0]          cells_y_r, cells_y_nxt;

  // Add region working registers: the four pixel bounds (sign extended), then
  // the resulting cell bounds.
  logic [17:0]            lx_r, lx_nxt, ly_r, ly_nxt;
  logic [17:0]            hx_r, hx_nxt, hy_r, hy_nxt;
  logic [XW-1:0]          x1_r, x1_nxt, x2_r, x2_nxt;
  logic [YW-1:0]          y1_r, y1_nxt, y2_r, y2_nxt;
  logic                   empty_r, empty_nxt;
  logic [YW-1:0]          row_r, row_nxt;
  logic [MAX_CELLS_X-1:0] mask_r, mask_nxt;

  // Build working registers.
  logic                   with_prev_r, with_prev_nxt;
  logic [5:0]             brow_r, brow_nxt;
  logic [MAX_CELLS_X-1:0] sh_r, sh_nxt;
  logic [XW-1:0]          col_r, col_nxt;
  logic [XW-1:0]          start_r, start_nxt;
  logic [XW-1:0]          len_r, len_nxt;

  logic                   out_strobe_r, out_strobe_nxt;
  out_item_t              out_data_r, out_data_nxt;

  // Shared divider.
  logic                   div_go;
  logic [DIV_W-1:0]       div_arg;
  logic                   div_done;
  logic [DIV_W-1:0]       div_q;

  // Row memories, one per bank.
  logic                   wr_en_a, wr_en_b, rd_en;
  logic [AW-1:0]          rd_addr;
  logic [MAX_CELLS_X-1:0] wr_data;
  logic [MAX_CELLS_X-1:0] rd_a, rd_b;

  logic [AW-1:0]          row_a, brow_a;
  logic [XW-1:0]          nxm1;
  logic [YW-1:0]          nym1;
  logic [XW-1:0]          q_satx, q_minx;
  logic [YW-1:0]          q_saty, q_miny;
  logic [MAX_CELLS_X-1:0] rest;
  logic [XW-1:0]          run_start, run_len;
  logic [XW+CS_W-1:0]     prod_x, prod_w;
  logic [6+CS_W-1:0]      prod_y;
  logic [17:0]            ext_l, ext_t, ext_w, ext_h;
  logic [MAX_CELLS_X-1:0] cur_bits, prev_bits, bld_bits;
  logic                   cur_v, prev_v;
  logic                   add_ok;

  // Magnitude of an 18 bit two's complement value; the bounds never exceed
  // 17 bits of magnitude.
  function automatic logic [DIV_W-1:0] mag18(input logic [17:0] v);
    logic [17:0] n;
    n = v[17] ? (~v + 18'd1) : v;
    return n[DIV_W-1:0];
  endfunction

  dcg_div #(
    .CELL_SIZE (CELL_SIZE)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .dividend (div_arg),
    .done     (div_done),
    .quotient (div_q)
  );

  dcg_ram #(
    .WIDTH  (MAX_CELLS_X),
    .DEPTH  (MAX_CELLS_Y),
    .ADDR_W (AW)
  ) u_ram_a (
    .clk     (clk),
    .wr_en   (wr_en_a),
    .wr_addr (row_a),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_a)
  );

  dcg_ram #(
    .WIDTH  (MAX_CELLS_X),
    .DEPTH  (MAX_CELLS_Y),
    .ADDR_W (AW)
  ) u_ram_b (
    .clk     (clk),
    .wr_en   (wr_en_b),
    .wr_addr (row_a),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_b)
  );

  assign busy      = (state_r != ST_IDLE);
  // An item takes precedence over a configuration write in the same cycle.
  assign cfg_ready = (state_r == ST_IDLE) && !start;

  assign row_a  = row_r[AW-1:0];
  assign brow_a = AW'(brow_r);

  // Saturated and clamped forms of the divider result.
  assign nxm1   = cells_x_r - XW'(1);
  assign nym1   = cells_y_r - YW'(1);
  assign q_satx = (div_q > DIV_W'(MAX_CELLS_X)) ? XW'(MAX_CELLS_X) : div_q[XW-1:0];
  assign q_saty = (div_q > DIV_W'(MAX_CELLS_Y)) ? YW'(MAX_CELLS_Y) : div_q[YW-1:0];
  assign q_minx = (div_q > DIV_W'(nxm1)) ? nxm1 : div_q[XW-1:0];
  assign q_miny = (div_q > DIV_W'(nym1)) ? nym1 : div_q[YW-1:0];

  assign ext_l = {{2{in_data.rect_left[15]}}, in_data.rect_left};
  assign ext_t = {{2{in_data.rect_top[15]}}, in_data.rect_top};
  assign ext_w = {{2{in_data.rect_width[15]}}, in_data.rect_width};
  assign ext_h = {{2{in_data.rect_height[15]}}, in_data.rect_height};

  // A region counts only with a positive size on a surface of at least one
  // cell in each direction.
  assign add_ok = !in_data.rect_width[15] && (in_data.rect_width != '0) &&
                  !in_data.rect_height[15] && (in_data.rect_height != '0) &&
                  (cells_x_r != '0) && (cells_y_r != '0);

  // Row read back for a build: invalid rows read as zero, and only columns
  // inside the surface are looked at.
  assign cur_v     = cur_bank_r ? valid_b_r[brow_a] : valid_a_r[brow_a];
  assign prev_v    = cur_bank_r ? valid_a_r[brow_a] : valid_b_r[brow_a];
  assign cur_bits  = cur_v ? (cur_bank_r ? rd_b : rd_a) : '0;
  assign prev_bits = (prev_v && with_prev_r) ? (cur_bank_r ? rd_a : rd_b) : '0;
  assign bld_bits  = (cur_bits | prev_bits) &
                     (ONES >> (XW'(MAX_CELLS_X) - cells_x_r));

  // Run bookkeeping during the scan: the bit under inspection is sh_r[0].
  assign rest      = sh_r >> 1;
  assign run_start = (len_r == '0) ? col_r : start_r;
  assign run_len   = len_r + XW'(1);
  assign prod_x    = {{CS_W{1'b0}}, run_start} * {{XW{1'b0}}, CS_V};
  assign prod_w    = {{CS_W{1'b0}}, run_len} * {{XW{1'b0}}, CS_V};
  assign prod_y    = {{CS_W{1'b0}}, brow_r} * {6'd0, CS_V};

  always_comb begin
    state_nxt      = state_r;
    cur_bank_nxt   = cur_bank_r;
    valid_a_nxt    = valid_a_r;
    valid_b_nxt    = valid_b_r;
    cells_x_nxt    = cells_x_r;
    cells_y_nxt    = cells_y_r;
    lx_nxt         = lx_r;
    ly_nxt         = ly_r;
    hx_nxt         = hx_r;
    hy_nxt         = hy_r;
    x1_nxt         = x1_r;
    x2_nxt         = x2_r;
    y1_nxt         = y1_r;
    y2_nxt         = y2_r;
    empty_nxt      = empty_r;
    row_nxt        = row_r;
    mask_nxt       = mask_r;
    with_prev_nxt  = with_prev_r;
    brow_nxt       = brow_r;
    sh_nxt         = sh_r;
    col_nxt        = col_r;
    start_nxt      = start_r;
    len_nxt        = len_r;
    out_strobe_nxt = 1'b0;
    out_data_nxt   = out_data_r;
    div_go         = 1'b0;
    div_arg        = mag18(lx_r);
    wr_en_a        = 1'b0;
    wr_en_b        = 1'b0;
    wr_data        = mask_r;
    rd_en          = 1'b0;
    rd_addr        = row_a;

    unique case (state_r)
      ST_IDLE: begin
        priority if (start) begin
          unique case (in_data.kind)
            KIND_BEGIN: begin
              // The banks swap; the one that becomes current starts empty.
              cur_bank_nxt = !cur_bank_r;
              if (cur_bank_r) begin
                valid_a_nxt = '0;
              end else begin
                valid_b_nxt = '0;
              end
            end
            KIND_ADD: begin
              lx_nxt = ext_l;
              ly_nxt = ext_t;
              hx_nxt = ext_l + ext_w - 18'd1;
              hy_nxt = ext_t + ext_h - 18'd1;
              if (add_ok) begin
                div_go    = 1'b1;
                div_arg   = mag18(ext_l);
                state_nxt = ST_ADD_X1;
              end
            end
            KIND_BUILD, KIND_DAMAGE: begin
              with_prev_nxt = (in_data.kind == KIND_DAMAGE);
              brow_nxt      = in_data.row_index;
              if ((int'(in_data.row_index) >= int'(cells_y_r)) || (cells_x_r == '0)) begin
                out_strobe_nxt    = 1'b1;
                out_data_nxt      = '0;
                out_data_nxt.last = 1'b1;
              end else begin
                state_nxt = ST_BLD_RD;
              end
            end
          endcase
        end else if (cfg_valid) begin
          // Any size change wipes both grids.
          valid_a_nxt = '0;
          valid_b_nxt = '0;
          div_go      = 1'b1;
          div_arg     = DIV_W'(cfg_data) + DIV_W'(CELL_SIZE - 1);
          if (cfg_index == CFG_SURF_WIDTH) begin
            state_nxt = ST_CFG_X;
          end else begin
            state_nxt = ST_CFG_Y;
          end
        end else begin
          // Nothing offered: stay idle.
          state_nxt = ST_IDLE;
        end
      end

      ST_CFG_X: begin
        if (div_done) begin
          cells_x_nxt = q_satx;
          state_nxt   = ST_IDLE;
        end
      end

      ST_CFG_Y: begin
        if (div_done) begin
          cells_y_nxt = q_saty;
          state_nxt   = ST_IDLE;
        end
      end

      ST_ADD_X1: begin
        div_arg = mag18(ly_r);
        if (div_done) begin
          x1_nxt    = lx_r[17] ? '0 : q_satx;
          div_go    = 1'b1;
          state_nxt = ST_ADD_Y1;
        end
      end

      ST_ADD_Y1: begin
        div_arg = mag18(hx_r);
        if (div_done) begin
          y1_nxt    = ly_r[17] ? '0 : q_saty;
          div_go    = 1'b1;
          state_nxt = ST_ADD_X2;
        end
      end

      ST_ADD_X2: begin
        div_arg = mag18(hy_r);
        if (div_done) begin
          // A negative right edge still lands in column zero when it is
          // within one cell of it, as the division truncates toward zero.
          if (hx_r[17]) begin
            x2_nxt    = '0;
            empty_nxt = (div_q != '0);
          end else begin
            x2_nxt    = q_minx;
            empty_nxt = 1'b0;
          end
          div_go    = 1'b1;
          state_nxt = ST_ADD_Y2;
        end
      end

      ST_ADD_Y2: begin
        if (div_done) begin
          y2_nxt   = hy_r[17] ? '0 : q_miny;
          mask_nxt = (ONES << x1_r) & (ONES >> (XW'(MAX_CELLS_X - 1) - x2_r));
          row_nxt  = y1_r;
          if (empty_r || (hy_r[17] && (div_q != '0)) || (x1_r > x2_r) ||
              (y1_r > (hy_r[17] ? '0 : q_miny))) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_MARK_RD;
          end
        end
      end

      ST_MARK_RD: begin
        rd_en     = 1'b1;
        rd_addr   = row_a;
        state_nxt = ST_MARK_WR;
      end

      ST_MARK_WR: begin
        if (cur_bank_r) begin
          wr_data            = (valid_b_r[row_a] ? rd_b : '0) | mask_r;
          wr_en_b            = 1'b1;
          valid_b_nxt[row_a] = 1'b1;
        end else begin
          wr_data            = (valid_a_r[row_a] ? rd_a : '0) | mask_r;
          wr_en_a            = 1'b1;
          valid_a_nxt[row_a] = 1'b1;
        end
        if (row_r == y2_r) begin
          state_nxt = ST_IDLE;
        end else begin
          row_nxt   = row_r + YW'(1);
          state_nxt = ST_MARK_RD;
        end
      end

      ST_BLD_RD: begin
        rd_en     = 1'b1;
        rd_addr   = brow_a;
        state_nxt = ST_BLD_LD;
      end

      ST_BLD_LD: begin
        sh_nxt  = bld_bits;
        col_nxt = '0;
        len_nxt = '0;
        if (bld_bits == '0) begin
          out_strobe_nxt    = 1'b1;
          out_data_nxt      = '0;
          out_data_nxt.last = 1'b1;
          state_nxt         = ST_IDLE;
        end else begin
          state_nxt = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // One column per cycle. A run is sent at its final marked cell, and
        // it is the last one when nothing is marked beyond it.
        sh_nxt  = rest;
        col_nxt = col_r + XW'(1);
        if (sh_r[0]) begin
          start_nxt = run_start;
          len_nxt   = run_len;
          if (!rest[0]) begin
            out_strobe_nxt     = 1'b1;
            out_data_nxt.out_x = 11'(prod_x);
            out_data_nxt.out_y = 11'(prod_y);
            out_data_nxt.out_w = 12'(prod_w);
            out_data_nxt.out_h = OUT_H;
            out_data_nxt.found = 1'b1;
            out_data_nxt.last  = (rest == '0);
            len_nxt            = '0;
            if (rest == '0) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cur_bank_r   <= 1'b0;
      valid_a_r    <= '0;
      valid_b_r    <= '0;
      cells_x_r    <= '0;
      cells_y_r    <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cur_bank_r   <= cur_bank_nxt;
      valid_a_r    <= valid_a_nxt;
      valid_b_r    <= valid_b_nxt;
      cells_x_r    <= cells_x_nxt;
      cells_y_r    <= cells_y_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lx_r        <= lx_nxt;
    ly_r        <= ly_nxt;
    hx_r        <= hx_nxt;
    hy_r        <= hy_nxt;
    x1_r        <= x1_nxt;
    x2_r        <= x2_nxt;
    y1_r        <= y1_nxt;
    y2_r        <= y2_nxt;
    empty_r     <= empty_nxt;
    row_r       <= row_nxt;
    mask_r      <= mask_nxt;
    with_prev_r <= with_prev_nxt;
    brow_r      <= brow_nxt;
    sh_r        <= sh_nxt;
    col_r       <= col_nxt;
    start_r     <= start_nxt;
    len_r       <= len_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  // The final result of a build row always coincides with the return to idle,
  // and only that result does.
  a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> (out_data_r.last == (state_r == ST_IDLE)))
    else $error("last flag does not match the end of the build transaction");

  // Results only come from a build in progress or an immediate empty marker.
  a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> $past(state_r == ST_SCAN || state_r == ST_BLD_LD ||
                           (state_r == ST_IDLE && start)))
    else $error("result strobe without a build transaction");

  // Marking stays within the computed row span.
  a_mark_rows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MARK_WR) |-> (row_r >= y1_r && row_r <= y2_r))
    else $error("row marking outside the region span");

  // A configuration write leaves both grids empty.
  a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cfg_valid && cfg_ready && rst_n) |-> (valid_a_r == '0 && valid_b_r == '0))
    else $error("grids not cleared by a configuration transaction");

endmodule

// ===== test/dcg_rect_checker.sv =====
module dcg_rect_checker
  import dcg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  in_item_t          in_data,
  input  logic              out_strobe,
  input  out_item_t         out_data,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [SURF_W-1:0] cfg_data,
  output int                fail_count,
  output int                pending
);

  localparam int CELL = CELL_SIZE_DEF;
  localparam int COLS = MAX_CELLS_X_DEF;
  localparam int ROWS = MAX_CELLS_Y_DEF;

  // Two banks of cell rows; cur_bank selects the one holding this frame.
  logic [COLS-1:0]   grid [2][ROWS];
  logic              cur_bank;
  logic [SURF_W-1:0] surf_w;
  logic [SURF_W-1:0] surf_h;
  out_item_t         expected_rects[$];
  out_item_t         want;

  function automatic int cell_count(input logic [SURF_W-1:0] px, input int limit);
    int c;
    c = (int'(px) + CELL - 1) / CELL;
    return (c > limit) ? limit : c;
  endfunction

  task automatic clear_banks();
    for (int b = 0; b < 2; b++)
      for (int r = 0; r < ROWS; r++)
        grid[b][r] = '0;
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] pred);
    if (got !== pred)
      report_mismatch($sformatf("%s is %0h, predicted %0h", name, got, pred));
  endtask

  // Appends one predicted result to the tail of the queue.
  task automatic note_rect(input out_item_t r);
    expected_rects = {expected_rects, r};
  endtask

  task automatic mark_region(input in_item_t it);
    int nx, ny, l, t, w, h, x1, y1, x2, y2;
    nx = cell_count(surf_w, COLS);
    ny = cell_count(surf_h, ROWS);
    l = int'($signed(it.rect_left));
    t = int'($signed(it.rect_top));
    w = int'($signed(it.rect_width));
    h = int'($signed(it.rect_height));
    if (nx <= 0 || ny <= 0 || w <= 0 || h <= 0) return;
    // Integer division truncates toward zero, as the block does.
    x1 = l / CELL;
    y1 = t / CELL;
    x2 = (l + w - 1) / CELL;
    y2 = (t + h - 1) / CELL;
    if (x1 < 0) x1 = 0;
    if (y1 < 0) y1 = 0;
    if (x2 > nx - 1) x2 = nx - 1;
    if (y2 > ny - 1) y2 = ny - 1;
    for (int cy = y1; cy <= y2; cy++)
      for (int cx = x1; cx <= x2; cx++)
        grid[cur_bank][cy][cx] = 1'b1;
  endtask

  task automatic scan_row(input in_item_t it);
    int nx, ny, cx, run_start, runs;
    logic [COLS-1:0] bits;
    out_item_t r;
    nx = cell_count(surf_w, COLS);
    ny = cell_count(surf_h, ROWS);
    r = '0;
    r.last = 1'b1;
    if (nx <= 0 || ny <= 0 || int'(it.row_index) >= ny) begin
      note_rect(r);
      return;
    end
    bits = grid[cur_bank][it.row_index];
    if (it.kind == KIND_DAMAGE) bits |= grid[!cur_bank][it.row_index];
    // Columns beyond the surface never take part in a run.
    if (nx < COLS) bits &= (({{(COLS-1){1'b0}}, 1'b1} << nx) - 1'b1);
    cx = 0;
    runs = 0;
    while (cx < nx) begin
      if (!bits[cx]) begin
        cx++;
      end else begin
        run_start = cx;
        while (cx < nx && bits[cx]) cx++;
        r.out_x = 11'(run_start * CELL);
        r.out_y = 11'(int'(it.row_index) * CELL);
        r.out_w = 12'((cx - run_start) * CELL);
        r.out_h = 12'(CELL);
        r.found = 1'b1;
        r.last  = ((bits >> cx) == '0);
        note_rect(r);
        runs++;
      end
    end
    if (runs == 0) begin
      r = '0;
      r.last = 1'b1;
      note_rect(r);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_banks();
      cur_bank   = 1'b0;
      surf_w     = '0;
      surf_h     = '0;
      fail_count = 0;
      expected_rects.delete();
    end else begin
      // Results are compared before this edge's item is predicted, since a
      // result leaving now cannot belong to an item taken at the same edge.
      if (out_strobe) begin
        if (expected_rects.size() == 0) begin
          report_mismatch($sformatf("result %0h arrived with nothing predicted", out_data));
        end else begin
          want = expected_rects.pop_front();
          check_field("out_x", 32'(out_data.out_x), 32'(want.out_x));
          check_field("out_y", 32'(out_data.out_y), 32'(want.out_y));
          check_field("out_w", 32'(out_data.out_w), 32'(want.out_w));
          check_field("out_h", 32'(out_data.out_h), 32'(want.out_h));
          check_field("found", 32'(out_data.found), 32'(want.found));
          check_field("last", 32'(out_data.last), 32'(want.last));
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_SURF_WIDTH) surf_w = cfg_data;
        else surf_h = cfg_data;
        clear_banks();
      end
      if (start && !busy) begin
        case (in_data.kind)
          KIND_BEGIN: begin
            cur_bank = !cur_bank;
            for (int r = 0; r < ROWS; r++) grid[cur_bank][r] = '0;
          end
          KIND_ADD: mark_region(in_data);
          default:  scan_row(in_data);
        endcase
      end
    end
    pending = expected_rects.size();
  end

endmodule

// ===== test/damage_cell_grid_tracker_tb.sv =====
// Top level of the damage grid test. It only makes stimulus and gives the
// verdict; the checker beside the block predicts every result and counts the
// mismatches.
module damage_cell_grid_tracker_tb;
  import dcg_pkg::*;

  // An add region transaction can keep the block busy through its four divisions
  // and a read and a write per touched row, without producing a result, so
  // this many quiet cycles are allowed before a register write and at the end.
  localparam int SETTLE_CYCLES = 400;
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 29;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              start;
  logic              busy;
  in_item_t          in_data;
  logic              out_strobe;
  out_item_t         out_data;
  logic              cfg_valid;
  logic              cfg_ready;
  logic              cfg_index;
  logic [SURF_W-1:0] cfg_data;

  int                mismatches;
  int                rects_waiting;
  int                idle_pct;
  logic [SURF_W-1:0] cur_w;
  logic [SURF_W-1:0] cur_h;
  logic [SURF_W-1:0] phase_w [PHASES];
  logic [SURF_W-1:0] phase_h [PHASES];

  damage_cell_grid_tracker dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  dcg_rect_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (mismatches),
    .pending    (rects_waiting)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Safety net: even the slowest correct run finishes far inside this time.
  initial begin
    #5000000;
    $display("damage_cell_grid_tracker test failed");
    $finish;
  end

  // Offers one item as a transaction. The sender may sit idle for a while
  // first, showing junk on the data lines with start low; the item is taken
  // at the first rising edge at which busy is low. Start is left high, so a
  // following item with no gap goes out with a single assignment.
  task automatic drive_item(input in_item_t item);
    logic [95:0] junk;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      junk = {$urandom, $urandom, $urandom};
      start   <= 1'b0;
      in_data <= junk[$bits(in_item_t)-1:0];
      @(negedge clk);
    end
    start   <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (busy);
  endtask

  // One register write transaction, held until the block shows ready.
  task automatic put_reg(input logic idx, input logic [SURF_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Registers are only written once the block has gone quiet: every predicted
  // result has been seen and any add region still being marked has had time
  // to finish.
  task automatic write_surface(input logic [SURF_W-1:0] w, input logic [SURF_W-1:0] h);
    @(negedge clk);
    start <= 1'b0;
    wait (rects_waiting == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
    put_reg(CFG_SURF_WIDTH, w);
    put_reg(CFG_SURF_HEIGHT, h);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_w = w;
    cur_h = h;
  endtask

  // Fields that an item kind does not use are left random, so that every bit
  // of the payload still toggles.
  function automatic in_item_t region_item(input int l, input int t, input int w, input int h);
    in_item_t it;
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    it = raw[$bits(in_item_t)-1:0];
    it.kind        = KIND_ADD;
    it.rect_left   = 16'(l);
    it.rect_top    = 16'(t);
    it.rect_width  = 16'(w);
    it.rect_height = 16'(h);
    return it;
  endfunction

  function automatic in_item_t row_item(input logic [1:0] kind, input int row);
    in_item_t it;
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    it = raw[$bits(in_item_t)-1:0];
    it.kind      = kind;
    it.row_index = 6'(row);
    return it;
  endfunction

  // Mostly well-formed traffic for the current surface: regions that land on
  // it, single cells that break rows into many runs, and scans of rows that
  // exist. The rest is raw noise, nonpositive sizes and rows out of range.
  function automatic in_item_t random_item();
    in_item_t it;
    logic [95:0] raw;
    int pick, sub, rows, cols;
    raw  = {$urandom, $urandom, $urandom};
    it   = raw[$bits(in_item_t)-1:0];
    pick = $urandom_range(99);
    sub  = $urandom_range(9);
    rows = (int'(cur_h) + CELL_SIZE_DEF - 1) / CELL_SIZE_DEF;
    cols = (int'(cur_w) + CELL_SIZE_DEF - 1) / CELL_SIZE_DEF;
    if (rows > MAX_CELLS_Y_DEF) rows = MAX_CELLS_Y_DEF;
    if (cols > MAX_CELLS_X_DEF) cols = MAX_CELLS_X_DEF;
    if (rows < 1) rows = 1;
    if (cols < 1) cols = 1;
    if (pick < 8) begin
      it.kind = KIND_BEGIN;
    end else if (pick < 55) begin
      if (sub == 0) begin
        it.kind = KIND_ADD;
      end else if (sub <= 3) begin
        it = region_item($urandom_range(0, cols - 1) * CELL_SIZE_DEF + $urandom_range(0, 31),
                         $urandom_range(0, rows - 1) * CELL_SIZE_DEF + $urandom_range(0, 31),
                         $urandom_range(1, 8), $urandom_range(1, 8));
      end else if (sub == 9) begin
        it = region_item(int'($urandom_range(0, 200)) - 50, $urandom_range(0, 200),
                         -int'($urandom_range(0, 5)), $urandom_range(0, 300));
      end else begin
        it = region_item(int'($urandom_range(0, int'(cur_w) + 64)) - 32,
                         int'($urandom_range(0, int'(cur_h) + 64)) - 32,
                         $urandom_range(1, 300), $urandom_range(1, 160));
      end
    end else begin
      it.kind = (pick < 78) ? KIND_BUILD : KIND_DAMAGE;
      if (sub >= 3) it.row_index = 6'($urandom_range(0, rows - 1));
    end
    return it;
  endfunction

  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_SURF_WIDTH;
    cfg_data  = '0;
    idle_pct  = 24;
    cur_w     = '0;
    cur_h     = '0;

    phase_w[0] = 12'd640;
    phase_h[0] = 12'd480;
    phase_w[1] = 12'd1;
    phase_h[1] = 12'd2048;
    phase_w[2] = 12'($urandom_range(1, 4095));
    phase_h[2] = 12'($urandom_range(1, 4095));
    phase_w[3] = 12'd2048;
    phase_h[3] = 12'd1;
    phase_w[4] = 12'd4095;
    phase_h[4] = 12'd4095;
    phase_w[5] = 12'($urandom_range(0, 300));
    phase_h[5] = 12'($urandom_range(0, 300));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // With both sizes still zero there are no cells: a scan gives the empty
    // marker and a region is dropped.
    drive_item(row_item(KIND_BUILD, 0));
    drive_item(region_item(0, 0, 100, 100));

    write_surface(12'd2048, 12'd2048);
    drive_item(row_item(KIND_BUILD, 0));
    drive_item(region_item(0, 0, 2048, 2048));
    drive_item(row_item(KIND_BUILD, 63));
    drive_item(row_item(KIND_DAMAGE, 0));
    drive_item(row_item(KIND_BEGIN, 0));
    // The far edge here is -2 pixels, which truncates to cell zero.
    drive_item(region_item(-32768, -32768, 32767, 32767));
    drive_item(row_item(KIND_BUILD, 0));
    drive_item(row_item(KIND_DAMAGE, 5));
    // Starts far beyond the grid, so the clamped span is empty.
    drive_item(region_item(32767, 32767, 32767, 32767));
    drive_item(region_item(100, 100, 0, 50));
    drive_item(region_item(100, 100, 50, -1));
    // Spans that clamp to nothing above and to the left of the grid.
    drive_item(region_item(-100, -100, 150, 40));
    drive_item(region_item(-40, 60, 1, 1));
    // Three separate runs in row two, the last clipped at the right edge.
    drive_item(region_item(64, 64, 1, 1));
    drive_item(region_item(160, 64, 64, 32));
    drive_item(region_item(2016, 64, 5000, 1));
    drive_item(row_item(KIND_BUILD, 2));
    drive_item(row_item(KIND_DAMAGE, 2));
    drive_item(row_item(KIND_BEGIN, 0));
    drive_item(row_item(KIND_BEGIN, 0));
    drive_item(row_item(KIND_DAMAGE, 2));
    drive_item(row_item(KIND_BUILD, 63));

    // A small surface of four by three cells; row three lies outside it.
    write_surface(12'd100, 12'd70);
    drive_item(region_item(0, 0, 32767, 32767));
    drive_item(row_item(KIND_BUILD, 3));
    drive_item(row_item(KIND_DAMAGE, 2));

    // Random traffic over several surface sizes, with the sender idling at
    // 24 percent, then 82 percent, then not at all.
    for (int p = 0; p < PHASES; p++) begin
      idle_pct = (p < 2) ? 24 : ((p < 4) ? 82 : 0);
      write_surface(phase_w[p], phase_h[p]);
      repeat (PHASE_ITEMS) drive_item(random_item());
    end

    @(negedge clk);
    start <= 1'b0;
    wait (rects_waiting == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && rects_waiting == 0) begin
      $display("damage_cell_grid_tracker test passed");
    end else begin
      $display("damage_cell_grid_tracker test failed");
    end
    $finish;
  end

endmodule
